// ===== rtl/contiguous_block_allocator_macros.svh =====
// Assertion macros shared by the allocator RTL.
`ifndef CONTIGUOUS_BLOCK_ALLOCATOR_MACROS_SVH
`define CONTIGUOUS_BLOCK_ALLOCATOR_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define CBA_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: lbl");

// The consequent holds in the cycle after the antecedent.
`define CBA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: lbl");

`endif

// ===== rtl/cba_pkg.sv =====
// Shared types and constants of the contiguous block allocator.
package cba_pkg;
   localparam int MAP_BLOCKS   = 256;
   localparam int WORD_BITS    = 8;
   localparam int WORDS        = MAP_BLOCKS / WORD_BITS;
   localparam int BLK_W        = $clog2(MAP_BLOCKS);
   localparam int LEN_W        = BLK_W + 1;
   localparam int WADDR_W      = $clog2(WORDS);
   localparam int BIT_W        = $clog2(WORD_BITS);
   localparam int SIZE_W       = 24;
   localparam int CSR_W        = 17;
   localparam int DIVD_W       = SIZE_W + 1;
   localparam int REM_W        = CSR_W + 1;
   localparam int DCNT_W       = $clog2(DIVD_W);
   localparam logic [CSR_W-1:0] BLOCK_BYTES_RESET = CSR_W'(4096);

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;
   localparam logic STATUS_OK       = 1'b0;
   localparam logic STATUS_NO_SPACE = 1'b1;

   typedef struct packed {
      logic              opcode;
      logic [SIZE_W-1:0] byte_size;
      logic [BLK_W-1:0]  first_block;
   } req_type;

   typedef struct packed {
      logic             status;
      logic [BLK_W-1:0] run_start;
      logic [LEN_W-1:0] run_length;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_DIV, ST_DECIDE, ST_SCAN_RD, ST_SCAN_EX, ST_MK_RD, ST_MK_WR
   } state_type;
endpackage

// ===== rtl/contiguous_block_allocator.sv =====
// Top level of the first-fit contiguous block allocator.
//
// One request beat is taken on req_data when start is high and busy is low.
// The opcode either allocates the first run of free blocks large enough for
// byte_size, or frees a run from first_block. Sizes are rounded up to whole
// blocks by a one-bit-per-cycle divider using csr_write_data's register.
// The usage map lives in a 32 x 8 bit memory with a registered read port.
// After the accepting edge the divider runs, then a decision state; an
// allocation then scans map words (up to 32 words) through read and examine
// states, and the run is updated (up to 32 words) through read and write states.
// A new request can be taken during the strobe cycle; requests are handled
// one at a time.
// Each result beat appears on rsp_data for exactly one cycle with rsp_valid
// high; the receiver cannot stall it.
// Reset marks every block free through per-word valid bits and restores a
// block size of 4096 bytes. No clearing pass is needed.
// The block size register may be written only while busy is low.
module contiguous_block_allocator (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  cba_pkg::req_type      req_data,
   output logic                  rsp_valid,
   output cba_pkg::rsp_type      rsp_data,
   input  logic                  csr_write_en,
   input  logic [cba_pkg::CSR_W-1:0] csr_write_data
);
   import cba_pkg::*;

   state_type               state_ff, state_in;
   logic [CSR_W-1:0]        bb_ff;
   logic [CSR_W-1:0]        divisor;
   logic                    op_ff, op_in;
   logic [BLK_W-1:0]        first_ff, first_in;
   logic [DIVD_W-1:0]       divd_ff, divd_in;
   logic [DIVD_W-1:0]       quot_ff, quot_in;
   logic [REM_W-1:0]        rem_ff, rem_in;
   logic [DCNT_W-1:0]       dcnt_ff, dcnt_in;
   logic [LEN_W-1:0]        need_ff, need_in;
   logic [LEN_W-1:0]        cnt_ff, cnt_in;
   logic [BLK_W-1:0]        runst_ff, runst_in;
   logic [WADDR_W-1:0]      wp_ff, wp_in;
   logic [WADDR_W-1:0]      last_ff, last_in;
   logic [BLK_W-1:0]        lo_ff, lo_in;
   logic [LEN_W-1:0]        hi_ff, hi_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_ff, rsp_in;

   logic [WORD_BITS-1:0]    mem [WORDS];
   logic [WORDS-1:0]        wvalid_ff;
   logic [WORD_BITS-1:0]    rd_raw_ff;
   logic                    rd_valid_ff;
   logic [WORD_BITS-1:0]    rd_word;
   logic                    mem_re;
   logic                    mem_we;
   logic [WORD_BITS-1:0]    wr_word;

   logic [REM_W-1:0]        rem_sh;
   logic                    div_done;
   logic [LEN_W-1:0]        room;
   logic [LEN_W-1:0]        free_len;
   logic                    scan_found;
   logic [LEN_W-1:0]        scan_cnt;
   logic [BLK_W-1:0]        scan_start;
   logic [LEN_W-1:0]        run_end;

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign divisor   = (bb_ff == '0) ? CSR_W'(1) : bb_ff;
   assign rd_word   = rd_valid_ff ? rd_raw_ff : '0;
   assign rem_sh    = {rem_ff[REM_W-2:0], divd_ff[DIVD_W-1]};
   assign div_done  = (dcnt_ff == DCNT_W'(DIVD_W - 1));
   assign room      = LEN_W'(MAP_BLOCKS) - LEN_W'(first_ff);
   assign free_len  = (quot_ff < DIVD_W'(room)) ? quot_ff[LEN_W-1:0] : room;
   assign mem_re    = (state_ff == ST_SCAN_RD) || (state_ff == ST_MK_RD);
   assign mem_we    = (state_ff == ST_MK_WR);

   always_comb begin
      scan_cnt   = cnt_ff;
      scan_start = runst_ff;
      scan_found = 1'b0;
      for (int b = 0; b < WORD_BITS; b++) begin
         if (!scan_found) begin
            if (!rd_word[b]) begin
               if (scan_cnt == '0) begin
                  scan_start = {wp_ff, BIT_W'(b)};
               end
               scan_cnt = scan_cnt + LEN_W'(1);
               if (scan_cnt == need_ff) begin
                  scan_found = 1'b1;
               end
            end else begin
               scan_cnt = '0;
            end
         end
      end
   end

   always_comb begin
      for (int b = 0; b < WORD_BITS; b++) begin
         if ((LEN_W'({wp_ff, BIT_W'(b)}) >= LEN_W'(lo_ff)) &&
             (LEN_W'({wp_ff, BIT_W'(b)}) < hi_ff)) begin
            wr_word[b] = (op_ff == OP_ALLOC);
         end else begin
            wr_word[b] = rd_word[b];
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:    if (start) state_in = ST_DIV;
         ST_DIV:     if (div_done) state_in = ST_DECIDE;
         ST_DECIDE: begin
            if (op_ff == OP_ALLOC) begin
               if (quot_ff == '0 || quot_ff > DIVD_W'(MAP_BLOCKS)) state_in = ST_IDLE;
               else state_in = ST_SCAN_RD;
            end else begin
               if (free_len == '0) state_in = ST_IDLE;
               else state_in = ST_MK_RD;
            end
         end
         ST_SCAN_RD: state_in = ST_SCAN_EX;
         ST_SCAN_EX: begin
            if (scan_found) state_in = ST_MK_RD;
            else if (wp_ff == WADDR_W'(WORDS - 1)) state_in = ST_IDLE;
            else state_in = ST_SCAN_RD;
         end
         ST_MK_RD:   state_in = ST_MK_WR;
         ST_MK_WR:   state_in = (wp_ff == last_ff) ? ST_IDLE : ST_MK_RD;
         default:    state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      op_in        = op_ff;
      first_in     = first_ff;
      divd_in      = divd_ff;
      quot_in      = quot_ff;
      rem_in       = rem_ff;
      dcnt_in      = dcnt_ff;
      need_in      = need_ff;
      cnt_in       = cnt_ff;
      runst_in     = runst_ff;
      wp_in        = wp_ff;
      last_in      = last_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      run_end      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               op_in    = req_data.opcode;
               first_in = req_data.first_block;
               divd_in  = DIVD_W'(req_data.byte_size) + DIVD_W'(divisor) - DIVD_W'(1);
               quot_in  = '0;
               rem_in   = '0;
               dcnt_in  = '0;
            end
         end
         ST_DIV: begin
            divd_in = {divd_ff[DIVD_W-2:0], 1'b0};
            dcnt_in = dcnt_ff + DCNT_W'(1);
            if (rem_sh >= REM_W'(divisor)) begin
               rem_in  = rem_sh - REM_W'(divisor);
               quot_in = {quot_ff[DIVD_W-2:0], 1'b1};
            end else begin
               rem_in  = rem_sh;
               quot_in = {quot_ff[DIVD_W-2:0], 1'b0};
            end
         end
         ST_DECIDE: begin
            if (op_ff == OP_ALLOC) begin
               if (quot_ff == '0 || quot_ff > DIVD_W'(MAP_BLOCKS)) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = '{status: STATUS_NO_SPACE, run_start: '0, run_length: '0};
               end else begin
                  need_in  = quot_ff[LEN_W-1:0];
                  cnt_in   = '0;
                  runst_in = '0;
                  wp_in    = '0;
               end
            end else begin
               if (free_len == '0) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = '{status: STATUS_OK, run_start: '0, run_length: '0};
               end else begin
                  run_end = LEN_W'(first_ff) + free_len;
                  need_in = free_len;
                  lo_in   = first_ff;
                  hi_in   = run_end;
                  wp_in   = first_ff[BLK_W-1:BIT_W];
                  last_in = WADDR_W'((run_end - LEN_W'(1)) >> BIT_W);
               end
            end
         end
         ST_SCAN_EX: begin
            cnt_in   = scan_cnt;
            runst_in = scan_start;
            if (scan_found) begin
               run_end = LEN_W'(scan_start) + need_ff;
               lo_in   = scan_start;
               hi_in   = run_end;
               wp_in   = scan_start[BLK_W-1:BIT_W];
               last_in = WADDR_W'((run_end - LEN_W'(1)) >> BIT_W);
            end else if (wp_ff == WADDR_W'(WORDS - 1)) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{status: STATUS_NO_SPACE, run_start: '0, run_length: '0};
            end else begin
               wp_in = wp_ff + WADDR_W'(1);
            end
         end
         ST_MK_WR: begin
            if (wp_ff == last_ff) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{status: STATUS_OK,
                                run_start: (op_ff == OP_ALLOC) ? lo_ff : '0,
                                run_length: need_ff};
            end else begin
               wp_in = wp_ff + WADDR_W'(1);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         bb_ff        <= BLOCK_BYTES_RESET;
         rsp_valid_ff <= 1'b0;
         wvalid_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_en) begin
            bb_ff <= csr_write_data;
         end
         if (mem_we) begin
            wvalid_ff[wp_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      first_ff <= first_in;
      divd_ff  <= divd_in;
      quot_ff  <= quot_in;
      rem_ff   <= rem_in;
      dcnt_ff  <= dcnt_in;
      need_ff  <= need_in;
      cnt_ff   <= cnt_in;
      runst_ff <= runst_in;
      wp_ff    <= wp_in;
      last_ff  <= last_in;
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      rsp_ff   <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wp_ff] <= wr_word;
      end
      if (mem_re) begin
         rd_raw_ff   <= mem[wp_ff];
         rd_valid_ff <= wvalid_ff[wp_ff];
      end
   end

`include "contiguous_block_allocator_macros.svh"

   `CBA_ASSERT_NEXT(a_start_busy, clock, reset, start && !busy, busy)
   `CBA_ASSERT_SAME(a_rsp_idle, clock, reset, rsp_valid, !busy)
   `CBA_ASSERT_NEXT(a_rsp_single, clock, reset, rsp_valid, !rsp_valid)
   `CBA_ASSERT_SAME(a_fail_zero, clock, reset, rsp_valid && rsp_data.status,
      rsp_data.run_start == '0 && rsp_data.run_length == '0)

endmodule
